// ===== design/ecc_pkg.sv =====
`timescale 1ns / 1ps
package ecc_pkg;
    localparam int Floors    = 16;
    localparam int FracBits  = 8;
    localparam int FloorW    = 4;
    localparam int PosW      = 13;
    localparam int VelW      = 10;
    localparam int DistW     = 14;
    localparam logic [PosW-1:0] One       = 13'd256;
    localparam logic [VelW-1:0] VelMax    = 10'd512;
    localparam logic [DistW-1:0] DecelZone = 14'd384;
    localparam logic [VelW-1:0] NearTol   = 10'd13;

    localparam logic [1:0] MOVE_IDLE = 2'd0;
    localparam logic [1:0] MOVE_UP   = 2'd1;
    localparam logic [1:0] MOVE_DOWN = 2'd2;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_UP   = 2'd1;
    localparam logic [1:0] OP_DOWN = 2'd2;
    localparam logic [1:0] OP_DEST = 2'd3;

    localparam logic [1:0] REG_FLOORS = 2'd0;
    localparam logic [1:0] REG_ACCEL  = 2'd1;
    localparam logic [1:0] REG_MASK   = 2'd2;
    localparam logic [1:0] REG_HOLD   = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic event_op;
        logic tick_start;
        logic scan_clear;
        logic scan_step;
        logic tick_eval;
        logic absorb_step;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic need_absorb;
        logic absorb_last;
        logic door_busy;
        logic need_rescan;
    } t_status;
endpackage

// ===== design/ecc_if.sv =====
`timescale 1ns / 1ps
interface ecc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [3:0] floor;
    logic [3:0] dest_floor;
    logic [1:0] request_dir;
    modport source (output valid, opcode, floor, dest_floor, request_dir, input ready);
    modport sink (input valid, opcode, floor, dest_floor, request_dir, output ready);
endinterface

interface ecc_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] car_position;
    logic [9:0]  car_velocity;
    logic [1:0]  travel_dir;
    logic        door_is_open;
    logic        stopped_here;
    modport source (output valid, car_position, car_velocity, travel_dir, door_is_open,
        stopped_here, input ready);
    modport sink (input valid, car_position, car_velocity, travel_dir, door_is_open,
        stopped_here, output ready);
endinterface

// ===== design/ecc_datapath.sv =====
`timescale 1ns / 1ps
module ecc_datapath import ecc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic [1:0]          i_opcode,
    input  logic [3:0]          i_floor,
    input  logic [3:0]          i_dest_floor,
    input  logic [1:0]          i_request_dir,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output logic [PosW-1:0]     o_position,
    output logic [VelW-1:0]     o_velocity,
    output logic [1:0]          o_dir,
    output logic                o_door,
    output logic                o_stopped
);
    // configuration
    logic [4:0]  r_floor_count;
    logic [9:0]  r_accel;
    logic [15:0] r_mask;
    logic [7:0]  r_hold;
    // car state
    logic [Floors-1:0] r_queue, r_up, r_down;
    logic [PosW-1:0]   r_pos;
    logic [VelW-1:0]   r_vel;
    logic [1:0]        r_dir;
    logic              r_door;
    logic [7:0]        r_timer;
    logic              r_stopped;
    logic              r_door_tick;   // door was open when the tick began
    // destination request memory, one row per origin floor
    logic [2*Floors-1:0] r_dest_mem [Floors];
    logic [2*Floors-1:0] r_dest_row;
    // scan state
    logic [FloorW-1:0] r_idx;
    logic              r_ahead_v, r_behind_v;
    logic [FloorW-1:0] r_ahead, r_behind;
    logic [DistW-1:0]  r_ahead_d, r_behind_d;
    logic              r_any;
    logic [FloorW-1:0] r_cur;
    logic              r_near_floor;
    logic [1:0]        r_phase;   // 0 first scan, 1 post-stop scan
    logic [FloorW-1:0] r_stop_f;
    logic              r_absorb;
    logic [1:0]        r_abs_dir;

    logic [4:0] served;
    assign served = (r_floor_count < 5'd2) ? 5'd2 :
                    (r_floor_count > 5'd16) ? 5'd16 : r_floor_count;
    logic [PosW-1:0] top_pos;
    assign top_pos = {served, 8'd0};

    // current floor rounding
    logic [PosW-1:0] pos_r;
    logic [FloorW:0] cur_w;
    logic [PosW-1:0] cur_fp;
    logic [PosW-1:0] off_abs;
    assign pos_r  = r_pos + 13'd128;
    assign cur_w  = pos_r[12:8] - 5'd1;
    assign cur_fp = {cur_w + 5'd1, 8'd0};
    assign off_abs = (r_pos > cur_fp) ? r_pos - cur_fp : cur_fp - r_pos;

    // one floor of the target scan
    logic             s_q, s_u, s_d, s_pend, s_same, s_geom, s_is_ahead;
    logic [FloorW:0]  s_idx_p1;
    logic [PosW-1:0]  s_fp;
    logic [DistW-1:0] s_dist;
    assign s_q = r_queue[r_idx];
    assign s_u = r_up[r_idx];
    assign s_d = r_down[r_idx];
    assign s_pend = s_q | s_u | s_d;
    assign s_idx_p1 = {1'b0, r_idx} + 5'd1;
    assign s_fp = {s_idx_p1, 8'd0};
    assign s_dist = {1'b0, (r_pos > s_fp) ? r_pos - s_fp : s_fp - r_pos};
    assign s_same = (r_dir == MOVE_UP && s_u) || (r_dir == MOVE_DOWN && s_d);
    assign s_geom = (r_dir == MOVE_UP && s_fp >= r_pos) ||
                    (r_dir == MOVE_DOWN && s_fp <= r_pos);
    assign s_is_ahead = (r_dir == MOVE_IDLE) || (s_geom && (s_q || s_same));

    logic              tgt_v;
    logic [FloorW-1:0] tgt;
    assign tgt_v = r_ahead_v | r_behind_v;
    assign tgt   = r_ahead_v ? r_ahead : r_behind;

    assign o_status.scan_last   = ({1'b0, r_idx} == served - 5'd1);
    assign o_status.absorb_last = ({1'b0, r_idx} == served - 5'd1);
    assign o_status.need_absorb = r_absorb;
    assign o_status.door_busy   = r_door_tick;
    assign o_status.need_rescan = (r_phase == 2'd1);

    // movement arithmetic
    logic [FloorW:0]  tgt_p1;
    logic [PosW-1:0]  tp;
    logic [DistW-1:0] tdist;
    logic [VelW+1:0]  v_ext;
    logic [VelW-1:0]  v_new;
    logic [PosW:0]    p_new;
    logic [PosW-1:0]  p_clamp;
    assign tgt_p1 = {1'b0, tgt} + 5'd1;
    assign tp = {tgt_p1, 8'd0};
    assign tdist = {1'b0, (r_pos > tp) ? r_pos - tp : tp - r_pos};
    always_comb begin
        if (tdist < DecelZone) v_ext = {2'b0, r_vel} - {2'b0, r_accel};
        else v_ext = {2'b0, r_vel} + {2'b0, r_accel};
        if (!v_ext[VelW+1] && v_ext > {2'b0, VelMax}) v_new = VelMax;
        else if (v_ext[VelW+1] || v_ext < {2'b0, NearTol}) v_new = NearTol;
        else v_new = v_ext[VelW-1:0];
        if (r_dir == MOVE_UP) p_new = {1'b0, r_pos} + {4'b0, v_new};
        else p_new = {1'b0, r_pos} - {4'b0, v_new};
        if (p_new[PosW] || p_new[PosW-1:0] < One) p_clamp = One;
        else if (p_new[PosW-1:0] > top_pos) p_clamp = top_pos;
        else p_clamp = p_new[PosW-1:0];
    end

    // destination entry of the stop floor under the absorb index
    logic [1:0] a_r;
    assign a_r = r_dest_row[{r_idx, 1'b0} +: 2];

    // destination memory: row read at the decision, cleared while absorbing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Floors; i++) r_dest_mem[i] <= '0;
        end else begin
            if (i_cmd.tick_eval) r_dest_row <= r_dest_mem[r_cur];
            if (i_cmd.event_op && i_opcode == OP_DEST && {1'b0, i_floor} < served &&
                {1'b0, i_dest_floor} < served)
                r_dest_mem[i_floor][{i_dest_floor, 1'b0} +: 2] <= i_request_dir;
            else if (i_cmd.absorb_step && (a_r == r_abs_dir))
                r_dest_mem[r_stop_f][{r_idx, 1'b0} +: 2] <= 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor_count <= 5'd16;
            r_accel <= 10'd26;
            r_mask <= 16'hFFFF;
            r_hold <= 8'd50;
            r_queue <= '0; r_up <= '0; r_down <= '0;
            r_pos <= One; r_vel <= '0; r_dir <= MOVE_IDLE;
            r_door <= 1'b0; r_timer <= '0; r_stopped <= 1'b0; r_door_tick <= 1'b0;
            r_idx <= '0; r_ahead_v <= 1'b0; r_behind_v <= 1'b0; r_any <= 1'b0;
            r_phase <= 2'd0; r_absorb <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FLOORS: begin
                        r_floor_count <= i_cfg_data[4:0];
                        if (r_pos < One) r_pos <= One;
                        else if (r_pos > {(i_cfg_data[4:0] < 5'd2) ? 5'd2 :
                            (i_cfg_data[4:0] > 5'd16) ? 5'd16 : i_cfg_data[4:0], 8'd0})
                            r_pos <= {(i_cfg_data[4:0] < 5'd2) ? 5'd2 :
                                (i_cfg_data[4:0] > 5'd16) ? 5'd16 : i_cfg_data[4:0], 8'd0};
                    end
                    REG_ACCEL: r_accel <= i_cfg_data[9:0];
                    REG_MASK:  r_mask <= i_cfg_data;
                    REG_HOLD:  r_hold <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // event updates
            if (i_cmd.event_op) begin
                r_stopped <= 1'b0;
                if ({1'b0, i_floor} < served) begin
                    if (i_opcode == OP_UP) r_up[i_floor] <= 1'b1;
                    else if (i_opcode == OP_DOWN) r_down[i_floor] <= 1'b1;
                end
            end
            // tick entry: door timer
            if (i_cmd.tick_start) begin
                r_stopped <= 1'b0;
                r_door_tick <= r_door;
                r_cur <= cur_w[FloorW-1:0];
                r_near_floor <= ({3'b0, NearTol} > off_abs);
                r_phase <= 2'd0;
                r_absorb <= 1'b0;
                if (r_door) begin
                    if (r_timer + 8'd1 >= r_hold) begin
                        r_door <= 1'b0; r_timer <= '0;
                    end else r_timer <= r_timer + 8'd1;
                end
            end
            if (i_cmd.scan_clear) begin
                r_idx <= '0; r_ahead_v <= 1'b0; r_behind_v <= 1'b0; r_any <= 1'b0;
            end
            // one floor of nearest search per cycle
            if (i_cmd.scan_step) begin
                if (s_pend) begin
                    r_any <= 1'b1;
                    if (s_is_ahead) begin
                        if (!r_ahead_v || s_dist < r_ahead_d) begin
                            r_ahead_v <= 1'b1; r_ahead <= r_idx; r_ahead_d <= s_dist;
                        end
                    end else if (!r_behind_v || s_dist < r_behind_d) begin
                        r_behind_v <= 1'b1; r_behind <= r_idx; r_behind_d <= s_dist;
                    end
                end
                r_idx <= r_idx + 4'd1;
            end
            // decision after a scan
            if (i_cmd.tick_eval) begin
                r_idx <= '0;
                if (r_phase == 2'd1) begin
                    if (!tgt_v || tgt == r_cur) r_dir <= MOVE_IDLE;
                    else r_dir <= (tgt > r_cur) ? MOVE_UP : MOVE_DOWN;
                end else if (r_dir == MOVE_IDLE) begin
                    if (!r_any) r_vel <= '0;
                    else if (tgt == r_cur) begin
                        r_stopped <= 1'b1;
                        r_vel <= '0; r_door <= 1'b1; r_queue[r_cur] <= 1'b0;
                        r_up[r_cur] <= 1'b0; r_down[r_cur] <= 1'b0;
                        r_stop_f <= r_cur;
                        r_abs_dir <= r_up[r_cur] ? MOVE_UP : MOVE_DOWN;
                        r_absorb <= r_up[r_cur] | r_down[r_cur];
                    end else r_dir <= (tgt > r_cur) ? MOVE_UP : MOVE_DOWN;
                end else if (r_near_floor && (r_queue[r_cur] ||
                        (r_dir == MOVE_UP && r_up[r_cur]) ||
                        (r_dir == MOVE_DOWN && r_down[r_cur]) ||
                        (tgt_v && tgt == r_cur))) begin
                    r_stopped <= 1'b1; r_phase <= 2'd1;
                    r_vel <= '0; r_door <= 1'b1; r_queue[r_cur] <= 1'b0;
                    r_up[r_cur] <= 1'b0; r_down[r_cur] <= 1'b0;
                    r_stop_f <= r_cur;
                    if (r_queue[r_cur] || (r_dir == MOVE_UP && r_up[r_cur]) ||
                        (r_dir == MOVE_DOWN && r_down[r_cur])) begin
                        r_abs_dir <= r_dir;
                        r_absorb <= (r_dir == MOVE_UP && r_up[r_cur]) ||
                                    (r_dir == MOVE_DOWN && r_down[r_cur]);
                    end else begin
                        r_abs_dir <= r_up[r_cur] ? MOVE_UP : MOVE_DOWN;
                        r_absorb <= r_up[r_cur] | r_down[r_cur];
                        if (r_up[r_cur]) r_dir <= MOVE_UP;
                        else if (r_down[r_cur]) r_dir <= MOVE_DOWN;
                    end
                end else if (!tgt_v) begin
                    r_dir <= MOVE_IDLE; r_vel <= '0;
                end else begin
                    r_vel <= v_new; r_pos <= p_clamp;
                end
            end
            // absorb destinations of the stop floor
            if (i_cmd.absorb_step) begin
                if (a_r == r_abs_dir && r_mask[r_idx]) r_queue[r_idx] <= 1'b1;
                r_idx <= r_idx + 4'd1;
                if (o_status.absorb_last) r_absorb <= 1'b0;
            end
        end
    end

    assign o_position = r_pos;
    assign o_velocity = r_vel;
    assign o_dir = r_dir;
    assign o_door = r_door;
    assign o_stopped = r_stopped;
endmodule

// ===== design/ecc_ctrl.sv =====
`timescale 1ns / 1ps
module ecc_ctrl import ecc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic [1:0] i_opcode,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DOOR   = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_EVAL   = 7'b0001000,
        S_ABSORB = 7'b0010000,
        S_RESCAN = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_post;   // second scan after a stop
    logic   n_post;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    // sequencing
    always_comb begin
        n_state = r_state;
        n_post  = r_post;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: if (i_in_valid && o_in_ready) begin
                if (i_opcode == OP_TICK) begin
                    o_cmd.tick_start = 1'b1;
                    n_state = S_DOOR;
                end else begin
                    o_cmd.event_op = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DOOR: begin
                o_cmd.scan_clear = 1'b1;
                n_post = 1'b0;
                n_state = i_status.door_busy ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.tick_eval = 1'b1;
                n_state = S_ABSORB;
            end
            S_ABSORB: begin
                if (r_post) n_state = S_DONE;
                else if (i_status.need_absorb) begin
                    o_cmd.absorb_step = 1'b1;
                    if (i_status.absorb_last) n_state = S_RESCAN;
                end else n_state = S_RESCAN;
            end
            // a stop while moving needs a second scan for the next direction
            S_RESCAN: begin
                if (i_status.need_rescan && !r_post) begin
                    o_cmd.scan_clear = 1'b1;
                    n_post = 1'b1;
                    n_state = S_SCAN;
                end else n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_post <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_post <= n_post;
            if (r_state == S_DONE) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_out_valid) else $error("accept while result waits");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_out_valid) else $error("result lost");
endmodule

// ===== design/elevator_car_controller.sv =====
`timescale 1ns / 1ps
// elevator car controller
// input channel: one transaction per event or tick (opcode, floor, dest_floor,
// request_dir); output channel: one transaction per input with car state
// configuration: plain write port, index 0 floor count, 1 acceleration,
// 2 floor present mask, 3 door hold ticks; write only while idle
// an event updates the call or destination state; a tick with the door open
// only advances the door timer; any other tick runs the one-floor-per-cycle
// nearest-request scan, the destination absorb after a stop and, for a stop
// while moving, a second scan for the next direction
// a new item is taken the cycle after the previous result has been taken
// reset: car at floor zero (position 1.0), idle, door closed, all calls clear
// receiver stall: the result holds in the output register and input stays
// blocked until it is taken
module elevator_car_controller import ecc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ecc_in_if.sink      in_ch,
    ecc_out_if.source   out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    t_cmd    cmd;
    t_status status;
    logic    in_ready, out_valid;

    ecc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ready), .i_opcode(in_ch.opcode),
        .o_out_valid(out_valid), .i_out_ready(out_ch.ready),
        .o_cmd(cmd), .i_status(status)
    );

    ecc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_opcode(in_ch.opcode), .i_floor(in_ch.floor), .i_dest_floor(in_ch.dest_floor),
        .i_request_dir(in_ch.request_dir),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_position(out_ch.car_position), .o_velocity(out_ch.car_velocity),
        .o_dir(out_ch.travel_dir), .o_door(out_ch.door_is_open),
        .o_stopped(out_ch.stopped_here)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;
endmodule

// ===== tb/tb_elevator_car_controller.sv =====
`timescale 1ns / 1ps
module tb_elevator_car_controller;
    import ecc_pkg::*;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] floor;
        logic [3:0] dest_floor;
        logic [1:0] request_dir;
    } t_event;

    typedef struct packed {
        logic [12:0] car_position;
        logic [9:0]  car_velocity;
        logic [1:0]  travel_dir;
        logic        door_is_open;
        logic        stopped_here;
    } t_car_state;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    ecc_in_if  in_ch ();
    ecc_out_if out_ch ();

    elevator_car_controller dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // model state of the car
    int unsigned m_floor_count, m_accel, m_mask, m_hold;
    bit m_car_q[Floors], m_up[Floors], m_down[Floors];
    logic [1:0] m_dest[Floors][Floors];
    int m_pos, m_vel, m_timer;
    logic [1:0] m_dir;
    bit m_door;

    t_event     pending_events[$];
    t_car_state expected_states[$];
    int error_count = 0;
    int cycle_count = 0;
    bit sender_pause = 1'b0;
    bit hold_request = 1'b0;
    bit receiver_hold = 1'b0;
    bit input_done = 1'b0;

    function automatic int served_floors();
        int n;
        n = m_floor_count;
        if (n < 2) n = 2;
        if (n > Floors) n = Floors;
        return n;
    endfunction

    function automatic void clamp_car();
        int top;
        top = served_floors() * 256;
        if (m_pos < 256) m_pos = 256;
        if (m_pos > top) m_pos = top;
    endfunction

    function automatic bit calls_waiting();
        for (int i = 0; i < served_floors(); i++)
            if (m_car_q[i] || m_up[i] || m_down[i]) return 1'b1;
        return 1'b0;
    endfunction

    // nearest pending floor, preferring those ahead; lowest wins ties
    function automatic int nearest_target();
        int ahead, behind, ahead_d, behind_d, fp, span;
        bit q, u, d, same, geom;
        ahead = -1; behind = -1; ahead_d = 0; behind_d = 0;
        for (int i = 0; i < served_floors(); i++) begin
            q = m_car_q[i]; u = m_up[i]; d = m_down[i];
            if (q || u || d) begin
                fp = (i + 1) * 256;
                span = m_pos > fp ? m_pos - fp : fp - m_pos;
                same = (m_dir == MOVE_UP && u) || (m_dir == MOVE_DOWN && d);
                geom = (m_dir == MOVE_UP && fp >= m_pos) ||
                       (m_dir == MOVE_DOWN && fp <= m_pos);
                if (m_dir == MOVE_IDLE || (geom && (q || same))) begin
                    if (ahead < 0 || span < ahead_d) begin ahead = i; ahead_d = span; end
                end else begin
                    if (behind < 0 || span < behind_d) begin behind = i; behind_d = span; end
                end
            end
        end
        return ahead >= 0 ? ahead : behind;
    endfunction

    function automatic bit call_matches_dir(int f);
        return (m_dir == MOVE_UP && m_up[f]) || (m_dir == MOVE_DOWN && m_down[f]);
    endfunction

    // open the door and take on destinations going our way
    function automatic void stop_car(int f);
        m_vel = 0;
        m_door = 1'b1;
        m_car_q[f] = 1'b0;
        if (call_matches_dir(f)) begin
            for (int i = 0; i < served_floors(); i++)
                if ((m_dir == MOVE_UP || m_dir == MOVE_DOWN) && m_dest[f][i] == m_dir) begin
                    if (m_mask[i]) m_car_q[i] = 1'b1;
                    m_dest[f][i] = 2'd0;
                end
        end
        m_up[f] = 1'b0;
        m_down[f] = 1'b0;
    endfunction

    function automatic bit run_tick();
        int cur, off, t, tp, span, v, nx;
        bit near;
        if (m_door) begin
            m_timer++;
            if (m_timer >= m_hold) begin m_door = 1'b0; m_timer = 0; end
            return 1'b0;
        end
        cur = ((m_pos + 128) >> 8) - 1;
        off = m_pos - (cur + 1) * 256;
        near = (off < 0 ? -off : off) < 13;
        if (m_dir == MOVE_IDLE) begin
            if (!calls_waiting()) begin m_vel = 0; return 1'b0; end
            t = nearest_target();
            if (t < 0) return 1'b0;
            if (t == cur) begin
                m_dir = m_up[cur] ? MOVE_UP : MOVE_DOWN;
                stop_car(cur);
                m_dir = MOVE_IDLE;
                return 1'b1;
            end
            m_dir = t > cur ? MOVE_UP : MOVE_DOWN;
            return 1'b0;
        end
        if (near) begin
            if (m_car_q[cur] || call_matches_dir(cur) || nearest_target() == cur) begin
                if (!(m_car_q[cur] || call_matches_dir(cur))) begin
                    if (m_up[cur]) m_dir = MOVE_UP;
                    else if (m_down[cur]) m_dir = MOVE_DOWN;
                end
                stop_car(cur);
                nx = calls_waiting() ? nearest_target() : -1;
                if (nx < 0 || nx == cur) m_dir = MOVE_IDLE;
                else m_dir = nx > cur ? MOVE_UP : MOVE_DOWN;
                return 1'b1;
            end
        end
        t = nearest_target();
        if (t < 0) begin m_dir = MOVE_IDLE; m_vel = 0; return 1'b0; end
        tp = (t + 1) * 256;
        span = m_pos > tp ? m_pos - tp : tp - m_pos;
        v = m_vel;
        if (span < 384) v -= int'(m_accel);
        else v += int'(m_accel);
        if (v > 512) v = 512;
        if (v < 13) v = 13;
        m_vel = v;
        if (m_dir == MOVE_UP) m_pos = m_pos + v;
        else m_pos = m_pos - v;
        clamp_car();
        return 1'b0;
    endfunction

    function automatic t_car_state predict_car(t_event ev);
        t_car_state r;
        bit stopped;
        int n;
        stopped = 1'b0;
        n = served_floors();
        if (ev.opcode == OP_TICK) stopped = run_tick();
        else if (ev.floor < n) begin
            if (ev.opcode == OP_UP) m_up[ev.floor] = 1'b1;
            else if (ev.opcode == OP_DOWN) m_down[ev.floor] = 1'b1;
            else if (ev.dest_floor < n) m_dest[ev.floor][ev.dest_floor] = ev.request_dir;
        end
        r.car_position = m_pos[12:0];
        r.car_velocity = m_vel[9:0];
        r.travel_dir = m_dir;
        r.door_is_open = m_door;
        r.stopped_here = stopped;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic int gap_length();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    // driver: offers queued events, predicting at acceptance
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.opcode <= '0;
            in_ch.floor <= '0;
            in_ch.dest_floor <= '0;
            in_ch.request_dir <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_states.push_back(predict_car(pending_events.pop_front()));
                send_gap = gap_length();
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) send_gap--;
                if (send_gap == 0 && !sender_pause && pending_events.size() > 0) begin
                    in_ch.valid <= 1'b1;
                    {in_ch.opcode, in_ch.floor, in_ch.dest_floor, in_ch.request_dir}
                        <= pending_events[0];
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver stall, counted in cycles here
    initial begin
        wait (hold_request);
        receiver_hold = 1'b1;
        repeat (300) @(posedge i_clk);
        receiver_hold = 1'b0;
    end

    // monitor: compares each car state transaction, with random back-pressure
    int recv_gap = 0;
    t_car_state want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_states.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    want = expected_states.pop_front();
                    if (out_ch.car_position !== want.car_position)
                        report_mismatch("car_position", out_ch.car_position, want.car_position);
                    if (out_ch.car_velocity !== want.car_velocity)
                        report_mismatch("car_velocity", out_ch.car_velocity, want.car_velocity);
                    if (out_ch.travel_dir !== want.travel_dir)
                        report_mismatch("travel_dir", out_ch.travel_dir, want.travel_dir);
                    if (out_ch.door_is_open !== want.door_is_open)
                        report_mismatch("door_is_open", out_ch.door_is_open, want.door_is_open);
                    if (out_ch.stopped_here !== want.stopped_here)
                        report_mismatch("stopped_here", out_ch.stopped_here, want.stopped_here);
                end
                recv_gap = gap_length();
            end
            if (receiver_hold) begin
                out_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 1000000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_event(logic [1:0] op, int f, int d, int rd);
        t_event ev;
        ev.opcode = op;
        ev.floor = f[3:0];
        ev.dest_floor = d[3:0];
        ev.request_dir = rd[1:0];
        pending_events.push_back(ev);
    endtask

    task automatic drain();
        while (pending_events.size() > 0 || expected_states.size() > 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[15:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FLOORS: begin m_floor_count = value & 32'h1F; clamp_car(); end
            REG_ACCEL: m_accel = value & 32'h3FF;
            REG_MASK: m_mask = value & 32'hFFFF;
            default: m_hold = value & 32'hFF;
        endcase
    endtask

    // random mix: calls, destinations with a matching call, lone destinations and tick bursts
    task automatic add_random_phase(int count);
        int f, d, k;
        k = 0;
        while (k < count) begin
            f = $urandom_range(0, 15);
            d = $urandom_range(0, 15);
            case ($urandom_range(0, 9))
                0: begin add_event(OP_UP, f, d, $urandom_range(0, 3)); k++; end
                1: begin add_event(OP_DOWN, f, d, $urandom_range(0, 3)); k++; end
                2, 3: begin
                    add_event(OP_DEST, f, d, d > f ? 1 : 2);
                    add_event(d > f ? OP_UP : OP_DOWN, f, $urandom_range(0, 15), 0);
                    k += 2;
                end
                4: begin add_event(OP_DEST, f, d, $urandom_range(0, 3)); k++; end
                default: begin
                    repeat ($urandom_range(1, 8)) add_event(OP_TICK, $urandom_range(0, 15),
                        $urandom_range(0, 15), $urandom_range(0, 3));
                    k++;
                end
            endcase
        end
    endtask

    initial begin
        m_floor_count = 16; m_accel = 26; m_mask = 16'hFFFF; m_hold = 50;
        m_pos = 256; m_vel = 0; m_dir = MOVE_IDLE; m_door = 1'b0; m_timer = 0;
        for (int i = 0; i < Floors; i++) begin
            m_car_q[i] = 0; m_up[i] = 0; m_down[i] = 0;
            for (int j = 0; j < Floors; j++) m_dest[i][j] = 2'd0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: quick door, calls at both ends, request codes incl. three
        write_reg(REG_HOLD, 0);
        add_event(OP_UP, 0, 0, 0);
        add_event(OP_TICK, 0, 0, 0);
        add_event(OP_TICK, 15, 15, 3);
        add_event(OP_DEST, 0, 15, 1);
        add_event(OP_DEST, 15, 0, 2);
        add_event(OP_DEST, 3, 7, 3);
        add_event(OP_DEST, 3, 7, 0);
        add_event(OP_UP, 15, 0, 0);
        add_event(OP_DOWN, 15, 0, 0);
        add_event(OP_UP, 0, 0, 0);
        repeat (14) add_event(OP_TICK, 0, 0, 0);
        drain();

        // long receiver hold-off while events keep coming
        hold_request = 1'b1;
        add_random_phase(16);
        drain();

        write_reg(REG_ACCEL, 512);
        write_reg(REG_HOLD, 255);
        add_random_phase(25);
        drain();

        write_reg(REG_FLOORS, 2);
        write_reg(REG_ACCEL, 0);
        write_reg(REG_MASK, 0);
        write_reg(REG_HOLD, 1);
        add_random_phase(25);
        drain();

        write_reg(REG_FLOORS, 0);
        add_random_phase(8);
        drain();

        write_reg(REG_FLOORS, 31);
        write_reg(REG_MASK, 16'hA5A5);
        write_reg(REG_ACCEL, 13);
        add_random_phase(40);
        // sender waits until everything outstanding is back
        sender_pause = 1'b1;
        while (expected_states.size() > 0 || in_ch.valid) @(posedge i_clk);
        sender_pause = 1'b0;
        drain();

        write_reg(REG_FLOORS, 9);
        write_reg(REG_MASK, 16'h5A5A);
        write_reg(REG_ACCEL, 64);
        write_reg(REG_HOLD, 3);
        add_random_phase(60);
        drain();

        write_reg(REG_FLOORS, 16);
        write_reg(REG_MASK, 16'hFFFF);
        write_reg(REG_ACCEL, 26);
        write_reg(REG_HOLD, 2);
        add_random_phase(60);
        drain();

        if (error_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/ecc_pkg.sv
design/ecc_if.sv
design/ecc_datapath.sv
design/ecc_ctrl.sv
design/elevator_car_controller.sv
tb/tb_elevator_car_controller.sv
